>>> rtl/core/sasm_pkg.sv
`timescale 1ns / 1ps

package sasm_pkg;

    // Defaults and fixed field widths
    localparam int MAX_SOURCES = 8;
    localparam int NUM_INPUTS  = 8;
    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 4;
    localparam int COUNT_RESET = 2;

    // Register file: one 32-bit register per word
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_SOURCE_COUNT = '0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t sample_0;
        sample_t sample_1;
        sample_t sample_2;
        sample_t sample_3;
        sample_t sample_4;
        sample_t sample_5;
        sample_t sample_6;
        sample_t sample_7;
        logic    last_in_period;
    } frame_beat_t;

    typedef struct packed {
        sample_t mixed_sample;
        logic    count_error;
        logic    last_out;
    } mixed_beat_t;

endpackage

>>> rtl/core/signed_audio_soft_mixer_top.sv
`timescale 1ns / 1ps

// Signed 16-bit soft mixer. Each frame beat carries up to eight source samples
// and yields one mixed beat. Pairs of same-sign samples mix as a+b-ab/32768
// (both positive) or a+b+ab/32768 (both negative); mixed-sign pairs add, and
// every intermediate result saturates to 16 bits. With three sources the
// all-positive and all-negative cases use a closed three-way form; otherwise
// the pairwise mix is folded over the sources in index order. A source_count
// below two returns zero with count_error set; a count above MAX_SOURCES is
// treated as MAX_SOURCES. source_count sits at APB address 0 (reset 2). The
// user must write it only while the mixer is empty; the block itself does not
// enforce this. One frame beat is accepted every cycle while frame_stall is
// low. Each beat passes through the fold chain: each of the MAX_SOURCES-1
// pairwise steps has a multiply stage and an add/saturate stage. Stalls on
// mixed_stall squeeze out bubbles first, so frame_stall rises only once every
// stage holds a beat.
module signed_audio_soft_mixer_top #(
    parameter int MAX_SOURCES = sasm_pkg::MAX_SOURCES
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sasm_pkg::PADDR_W-1:0]  paddr,
    input  logic [sasm_pkg::PDATA_W-1:0]  pwdata,
    output logic [sasm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,

    input  logic                          frame_valid,
    output logic                          frame_stall,
    input  sasm_pkg::frame_beat_t         frame_data,

    output logic                          mixed_valid,
    input  logic                          mixed_stall,
    output sasm_pkg::mixed_beat_t         mix_result
);

    localparam int NSTEP = MAX_SOURCES - 1;
    localparam int DEPTH = 2 * NSTEP;
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);

    // Pairwise mix flavor chosen by the signs of the two operands
    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_POS   = 2'd1,
        MODE_NEG   = 2'd2
    } mix_mode_t;

    // Everything that rides along with a beat through every stage
    typedef struct packed {
        logic                                           last;
        logic                                           err;
        logic [CNT_W-1:0]                               cnt;
        sasm_pkg::sample_t                              r;
        sasm_pkg::sample_t [sasm_pkg::NUM_INPUTS-1:0]   smp;
    } pipe_t;

    function automatic sasm_pkg::sample_t sat16(input logic signed [20:0] v);
        sasm_pkg::sample_t res;
        if (v > 21'sd32767)
        begin
            res = 16'sh7fff;
        end
        else if (v < -21'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [sasm_pkg::COUNT_W-1:0] source_count_reg;
    logic [sasm_pkg::COUNT_W-1:0] source_count_next;
    logic                         cfg_hit;

    assign cfg_hit = (paddr[sasm_pkg::PADDR_W-1:2] == sasm_pkg::REG_SOURCE_COUNT);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? sasm_pkg::PDATA_W'(source_count_reg) : '0;

    always_comb
    begin
        source_count_next = source_count_reg;
        if (psel && penable && pwrite && pready && cfg_hit)
        begin
            source_count_next = pwdata[sasm_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= sasm_pkg::COUNT_W'(sasm_pkg::COUNT_RESET);
        end
        else
        begin
            source_count_reg <= source_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage control: a stage advances when it or any stage after it is
    // empty, or when mixed_stall is low, so bubbles collapse under a stall.
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] v_reg;
    logic [DEPTH-1:0] v_next;
    logic [DEPTH-1:0] v_prev;
    logic [DEPTH-1:0] en;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_en
        assign en[i] = ~(&v_reg[DEPTH-1:i]) | ~mixed_stall;
    end

    if (DEPTH > 1)
    begin : g_vprev
        assign v_prev = {v_reg[DEPTH-2:0], frame_valid};
    end
    else
    begin : g_vprev1
        assign v_prev = frame_valid;
    end

    assign v_next = (en & v_prev) | (~en & v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign frame_stall = ~en[0];
    assign mixed_valid = v_reg[DEPTH-1];

    // ------------------------------------------------------------------
    // Entry: clamp the count, flag errors, seed the running mix
    // ------------------------------------------------------------------
    pipe_t in_pipe;

    always_comb
    begin
        in_pipe.last   = frame_data.last_in_period;
        in_pipe.err    = (source_count_reg < sasm_pkg::COUNT_W'(2));
        if (source_count_reg > sasm_pkg::COUNT_W'(MAX_SOURCES))
        begin
            in_pipe.cnt = CNT_W'(MAX_SOURCES);
        end
        else
        begin
            in_pipe.cnt = CNT_W'(source_count_reg);
        end
        in_pipe.smp[0] = frame_data.sample_0;
        in_pipe.smp[1] = frame_data.sample_1;
        in_pipe.smp[2] = frame_data.sample_2;
        in_pipe.smp[3] = frame_data.sample_3;
        in_pipe.smp[4] = frame_data.sample_4;
        in_pipe.smp[5] = frame_data.sample_5;
        in_pipe.smp[6] = frame_data.sample_6;
        in_pipe.smp[7] = frame_data.sample_7;
        in_pipe.r      = frame_data.sample_0;
    end

    pipe_t carry_reg [DEPTH];

    // ------------------------------------------------------------------
    // Three-source closed form, four stages alongside the first two fold
    // steps; its result replaces the fold at the add stage of step two.
    // ------------------------------------------------------------------
    logic              tri_use;
    sasm_pkg::sample_t tri_r;

    if (MAX_SOURCES >= 3)
    begin : g_tri
        logic signed [31:0] ab_reg;
        logic signed [31:0] ac_reg;
        logic signed [31:0] bc_reg;
        logic signed [17:0] tsum_reg;
        sasm_pkg::sample_t  tc_reg;
        logic               tpos_reg;
        logic               tneg_reg;

        logic signed [47:0] abc_reg;
        logic signed [19:0] tv_reg;
        logic               tneg1_reg;
        logic               tsel1_reg;

        logic signed [16:0] abq_reg;
        logic signed [19:0] tv2_reg;
        logic               tsel2_reg;

        sasm_pkg::sample_t  a;
        sasm_pkg::sample_t  b;
        sasm_pkg::sample_t  c;
        logic signed [18:0] pairs;
        logic signed [19:0] tv_next;
        logic signed [47:0] abc_adj;

        assign a = in_pipe.smp[0];
        assign b = in_pipe.smp[1];
        assign c = in_pipe.smp[2];

        // Same-sign operands make every pair product non-negative
        assign pairs = $signed({3'b000, ab_reg[30:15]})
                     + $signed({3'b000, ac_reg[30:15]})
                     + $signed({3'b000, bc_reg[30:15]});
        assign tv_next = tpos_reg ? (20'(tsum_reg) - 20'(pairs))
                                  : (20'(tsum_reg) + 20'(pairs));

        // Truncate the triple product toward zero
        assign abc_adj = tneg1_reg ? (abc_reg + 48'sh0000_3fff_ffff) : abc_reg;

        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                ab_reg   <= a * b;
                ac_reg   <= a * c;
                bc_reg   <= b * c;
                tsum_reg <= 18'(a) + 18'(b) + 18'(c);
                tc_reg   <= c;
                tpos_reg <= (a > 16'sd0) && (b > 16'sd0) && (c > 16'sd0);
                tneg_reg <= (a < 16'sd0) && (b < 16'sd0) && (c < 16'sd0);
            end
            if (en[1])
            begin
                abc_reg   <= ab_reg * tc_reg;
                tv_reg    <= tv_next;
                tneg1_reg <= tneg_reg;
                tsel1_reg <= tpos_reg | tneg_reg;
            end
            if (en[2])
            begin
                abq_reg   <= abc_adj[46:30];
                tv2_reg   <= tv_reg;
                tsel2_reg <= tsel1_reg;
            end
        end

        assign tri_r   = sat16(21'(tv2_reg) + 21'(abq_reg));
        assign tri_use = tsel2_reg && (carry_reg[2].cnt == CNT_W'(3));
    end
    else
    begin : g_notri
        assign tri_r   = '0;
        assign tri_use = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fold chain: step k mixes the running value with source k
    // ------------------------------------------------------------------
    mix_mode_t          mode_reg [NSTEP];
    logic               act_reg  [NSTEP];
    logic signed [31:0] prod_reg [NSTEP];
    logic signed [16:0] sum_reg  [NSTEP];

    for (genvar k = 1; k <= NSTEP; k++)
    begin : g_step
        localparam int MI = 2 * k - 2;
        localparam int AI = 2 * k - 1;

        pipe_t              src;
        pipe_t              add_next;
        mix_mode_t          mode_next;
        sasm_pkg::sample_t  x;
        logic signed [16:0] q;
        logic signed [18:0] v;
        sasm_pkg::sample_t  mixed;

        if (MI == 0)
        begin : g_first
            assign src = in_pipe;
        end
        else
        begin : g_chain
            assign src = carry_reg[MI-1];
        end

        assign x = src.smp[k];

        always_comb
        begin
            if ((src.r > 16'sd0) && (x > 16'sd0))
            begin
                mode_next = MODE_POS;
            end
            else if ((src.r < 16'sd0) && (x < 16'sd0))
            begin
                mode_next = MODE_NEG;
            end
            else
            begin
                mode_next = MODE_PLAIN;
            end
        end

        // Multiply stage
        always_ff @(posedge clk)
        begin
            if (en[MI])
            begin
                mode_reg[k-1]  <= mode_next;
                act_reg[k-1]   <= (CNT_W'(k) < src.cnt);
                prod_reg[k-1]  <= src.r * x;
                sum_reg[k-1]   <= 17'(src.r) + 17'(x);
                carry_reg[MI]  <= src;
            end
        end

        // Product is non-negative whenever it is used
        assign q = $signed({1'b0, prod_reg[k-1][30:15]});

        always_comb
        begin
            case (mode_reg[k-1])
                MODE_POS:   v = 19'(sum_reg[k-1]) - 19'(q);
                MODE_NEG:   v = 19'(sum_reg[k-1]) + 19'(q);
                MODE_PLAIN: v = 19'(sum_reg[k-1]);
                default:    v = 19'(sum_reg[k-1]);
            endcase
        end

        assign mixed = sat16(21'(v));

        always_comb
        begin
            add_next = carry_reg[MI];
            if ((k == 2) && tri_use)
            begin
                add_next.r = tri_r;
            end
            else if (act_reg[k-1])
            begin
                add_next.r = mixed;
            end
        end

        // Add and saturate stage
        always_ff @(posedge clk)
        begin
            if (en[AI])
            begin
                carry_reg[AI] <= add_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output beat
    // ------------------------------------------------------------------
    assign mix_result.mixed_sample = carry_reg[DEPTH-1].err ? '0 : carry_reg[DEPTH-1].r;
    assign mix_result.count_error  = carry_reg[DEPTH-1].err;
    assign mix_result.last_out     = carry_reg[DEPTH-1].last;

endmodule

>>> bench/signed_audio_soft_mixer_top_test.sv
`timescale 1ns / 1ps

module signed_audio_soft_mixer_top_test;

    // Fixed-point constants of the pairwise and three-way mix
    localparam longint MIX_SCALE    = 64'sd32768;
    localparam longint MIX_SCALE_SQ = 64'sd1073741824;

    // Pipeline depth is 2*(MAX_SOURCES-1); leave some margin past it
    localparam int DRAIN_CYCLES   = 2 * sasm_pkg::MAX_SOURCES + 6;
    // Longest quiet stretch is the long hold-off; allow several times that
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 150;
    localparam int NUM_PHASES     = 12;
    localparam int REPORT_LIMIT   = 10;

    // Idle modes of the two channels
    localparam int MODE_FREE       = 0;
    localparam int MODE_SEND_IDLE  = 1;
    localparam int MODE_RECV_STALL = 2;
    localparam int MODE_BOTH       = 3;

    // Sign mix of a random frame
    localparam int POL_POS = 0;
    localparam int POL_NEG = 1;
    localparam int POL_ANY = 2;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [sasm_pkg::PADDR_W-1:0]   paddr   = '0;
    logic [sasm_pkg::PDATA_W-1:0]   pwdata  = '0;
    logic [sasm_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    logic                           frame_valid = 1'b0;
    logic                           frame_stall;
    sasm_pkg::frame_beat_t          frame_data  = '0;

    logic                           mixed_valid;
    logic                           mixed_stall = 1'b0;
    sasm_pkg::mixed_beat_t          mix_result;

    // Frames waiting to be offered, and mixed beats predicted but not yet seen
    sasm_pkg::frame_beat_t          frame_backlog[$];
    sasm_pkg::mixed_beat_t          predicted_mixes[$];

    // Bench copy of the source_count register
    logic [sasm_pkg::COUNT_W-1:0]   cur_source_count = sasm_pkg::COUNT_W'(sasm_pkg::COUNT_RESET);

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    int frames_sent    = 0;
    int mixes_checked  = 0;
    int mismatches     = 0;
    int settings_tried = 1;
    int quiet_cycles   = 0;

    signed_audio_soft_mixer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_data  (frame_data),
        .mixed_valid (mixed_valid),
        .mixed_stall (mixed_stall),
        .mix_result  (mix_result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Mixing predictor
    // ------------------------------------------------------------------

    // Saturate a wide intermediate to the 16-bit sample range
    function automatic sasm_pkg::sample_t sat16(longint v);
        if (v > 64'sd32767)
            return 16'sh7fff;
        if (v < -64'sd32768)
            return 16'sh8000;
        return sasm_pkg::sample_t'(v);
    endfunction

    function automatic sasm_pkg::sample_t sat_add(sasm_pkg::sample_t a, sasm_pkg::sample_t b);
        return sat16(longint'(a) + longint'(b));
    endfunction

    // Both positive: a+b-ab/32768
    function automatic sasm_pkg::sample_t mix_pos(sasm_pkg::sample_t a, sasm_pkg::sample_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat16(longint'(a) + longint'(b) - p / MIX_SCALE);
    endfunction

    // Both negative: a+b+ab/32768
    function automatic sasm_pkg::sample_t mix_neg(sasm_pkg::sample_t a, sasm_pkg::sample_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat16(longint'(a) + longint'(b) + p / MIX_SCALE);
    endfunction

    // Pairwise mix; mixed sign or a zero just adds
    function automatic sasm_pkg::sample_t mix_pair(sasm_pkg::sample_t a, sasm_pkg::sample_t b);
        if (a > 0 && b > 0)
            return mix_pos(a, b);
        if (a < 0 && b < 0)
            return mix_neg(a, b);
        return sat_add(a, b);
    endfunction

    // Closed three-way form when all three share a sign
    function automatic sasm_pkg::sample_t mix_three_same(sasm_pkg::sample_t a,
                                                         sasm_pkg::sample_t b,
                                                         sasm_pkg::sample_t c,
                                                         bit positive);
        longint ab;
        longint ac;
        longint bc;
        longint abc;
        longint v;
        longint pairs;
        ab    = longint'(a) * longint'(b);
        ac    = longint'(a) * longint'(c);
        bc    = longint'(b) * longint'(c);
        abc   = ab * longint'(c);
        v     = longint'(a) + longint'(b) + longint'(c);
        pairs = ab / MIX_SCALE + ac / MIX_SCALE + bc / MIX_SCALE;
        v     = positive ? v - pairs : v + pairs;
        v     = v + abc / MIX_SCALE_SQ;
        return sat16(v);
    endfunction

    // Sign case tree for three sources
    function automatic sasm_pkg::sample_t mix_three(sasm_pkg::sample_t a,
                                                    sasm_pkg::sample_t b,
                                                    sasm_pkg::sample_t c);
        if (a > 0)
        begin
            if (b > 0)
            begin
                if (c > 0)
                    return mix_three_same(a, b, c, 1'b1);
                return sat_add(mix_pos(a, b), c);
            end
            if (b < 0)
                return mix_pair(sat_add(a, b), c);
            if (c > 0)
                return mix_pos(a, c);
            return sat_add(a, c);
        end
        if (a < 0)
        begin
            if (b < 0)
            begin
                if (c < 0)
                    return mix_three_same(a, b, c, 1'b0);
                return sat_add(mix_neg(a, b), c);
            end
            if (b > 0)
                return mix_pair(sat_add(a, b), c);
            if (c < 0)
                return mix_neg(a, c);
            return sat_add(a, c);
        end
        return mix_pair(b, c);
    endfunction

    // Expected mixed beat for one frame under a given source count
    function automatic sasm_pkg::mixed_beat_t mix_frame(sasm_pkg::frame_beat_t f,
                                                        logic [sasm_pkg::COUNT_W-1:0] count);
        sasm_pkg::sample_t     s[sasm_pkg::NUM_INPUTS];
        int                    n;
        sasm_pkg::sample_t     r;
        sasm_pkg::mixed_beat_t m;
        s[0] = f.sample_0;
        s[1] = f.sample_1;
        s[2] = f.sample_2;
        s[3] = f.sample_3;
        s[4] = f.sample_4;
        s[5] = f.sample_5;
        s[6] = f.sample_6;
        s[7] = f.sample_7;
        n = (int'(count) > sasm_pkg::MAX_SOURCES) ? sasm_pkg::MAX_SOURCES : int'(count);
        r = '0;
        m.count_error = 1'b0;
        if (n < 2)
            m.count_error = 1'b1;
        else if (n == 2)
            r = mix_pair(s[0], s[1]);
        else if (n == 3)
            r = mix_three(s[0], s[1], s[2]);
        else
        begin
            r = mix_pair(s[0], s[1]);
            for (int j = 2; j < n; j++)
                r = mix_pair(r, s[j]);
        end
        m.mixed_sample = r;
        m.last_out     = f.last_in_period;
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Pick a sample, biased toward full scale, unit and small magnitudes
    function automatic sasm_pkg::sample_t pick_sample(int polarity);
        int  mag;
        int  kind;
        bit  neg;
        kind = $urandom_range(9);
        case (kind)
            0:       mag = 32768;
            1:       mag = 1;
            2:       mag = $urandom_range(255, 1);
            3, 4:    mag = $urandom_range(32768, 28000);
            default: mag = $urandom_range(32768, 1);
        endcase
        if (polarity == POL_POS)
            neg = 1'b0;
        else if (polarity == POL_NEG)
            neg = 1'b1;
        else
        begin
            if ($urandom_range(7) == 0)
                return '0;
            neg = 1'($urandom_range(1));
        end
        if (!neg && mag > 32767)
            mag = 32767;
        return neg ? sasm_pkg::sample_t'(-mag) : sasm_pkg::sample_t'(mag);
    endfunction

    // Mostly same-sign frames so the saturating branches get exercised
    function automatic sasm_pkg::frame_beat_t random_frame();
        sasm_pkg::frame_beat_t f;
        int                    sel;
        int                    pol;
        sel = $urandom_range(9);
        pol = (sel < 3) ? POL_POS : (sel < 6) ? POL_NEG : POL_ANY;
        f.sample_0       = pick_sample(pol);
        f.sample_1       = pick_sample(pol);
        f.sample_2       = pick_sample(pol);
        f.sample_3       = pick_sample(pol);
        f.sample_4       = pick_sample(pol);
        f.sample_5       = pick_sample(pol);
        f.sample_6       = pick_sample(pol);
        f.sample_7       = pick_sample(pol);
        f.last_in_period = ($urandom_range(7) == 0);
        return f;
    endfunction

    // Directed frame: sources 3..7 repeat c so full-scale cases cover all eight
    function automatic sasm_pkg::frame_beat_t make_frame(sasm_pkg::sample_t a,
                                                         sasm_pkg::sample_t b,
                                                         sasm_pkg::sample_t c);
        sasm_pkg::frame_beat_t f;
        f.sample_0       = a;
        f.sample_1       = b;
        f.sample_2       = c;
        f.sample_3       = c;
        f.sample_4       = c;
        f.sample_5       = c;
        f.sample_6       = c;
        f.sample_7       = c;
        f.last_in_period = 1'($urandom_range(1));
        return f;
    endfunction

    task automatic set_idle(int mode);
        case (mode)
            MODE_SEND_IDLE:
            begin
                send_idle_pct  = 48;
                recv_stall_pct = 0;
            end
            MODE_RECV_STALL:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 48;
            end
            MODE_BOTH:
            begin
                send_idle_pct  = 6;
                recv_stall_pct = 6;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Hold until every queued frame went in and every mixed beat came back
    task automatic wait_all_mixed();
        while (frame_backlog.size() != 0 || frame_valid || predicted_mixes.size() != 0)
            @(posedge clk);
    endtask

    // APB write of source_count; waits for the mixer to drain first
    task automatic write_source_count(logic [sasm_pkg::COUNT_W-1:0] value);
        wait_all_mixed();
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sasm_pkg::PADDR_W'(sasm_pkg::REG_SOURCE_COUNT) << 2;
        pwdata  <= sasm_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_source_count = value;
        settings_tried++;
    endtask

    // ------------------------------------------------------------------
    // Frame driver: present the backlog head, hold it while stalled
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bit taken;
        if (!rst_n)
        begin
            frame_valid <= 1'b0;
        end
        else
        begin
            taken = frame_valid && !frame_stall;
            if (taken)
            begin
                predicted_mixes.push_back(mix_frame(frame_data, cur_source_count));
                frames_sent++;
            end
            // Advance only once the current beat is gone; a stalled beat stays put
            if (!frame_valid || taken)
            begin
                if (frame_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    frame_data  <= frame_backlog.pop_front();
                    frame_valid <= 1'b1;
                end
                else
                begin
                    frame_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Mixed-beat monitor: check against the oldest prediction, drive stall
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        sasm_pkg::mixed_beat_t want;
        bit                    bad;
        bit                    stall_next;
        if (!rst_n)
        begin
            mixed_stall <= 1'b0;
        end
        else
        begin
            if (mixed_valid && !mixed_stall)
            begin
                bad = 1'b0;
                if (predicted_mixes.size() == 0)
                begin
                    bad  = 1'b1;
                    want = 'x;
                end
                else
                begin
                    want = predicted_mixes.pop_front();
                    bad  = (mix_result.mixed_sample !== want.mixed_sample) ||
                           (mix_result.count_error !== want.count_error) ||
                           (mix_result.last_out !== want.last_out);
                end
                mixes_checked++;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch at beat %0d: want %0d/%0b/%0b got %0d/%0b/%0b%s",
                                 mixes_checked, want.mixed_sample, want.count_error,
                                 want.last_out, mix_result.mixed_sample,
                                 mix_result.count_error, mix_result.last_out,
                                 (predicted_mixes.size() == 0 && want === 'x) ?
                                 " (nothing expected)" : "");
                end
            end
            // Start a long hold-off when asked; the sender keeps offering meanwhile
            if (holds_served != hold_requests)
            begin
                hold_left    = LONG_HOLD;
                holds_served = hold_requests;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                stall_next = ($urandom_range(99) < recv_stall_pct);
            end
            mixed_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no handshake of any kind happens for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frame_valid && !frame_stall) || (mixed_valid && !mixed_stall) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d mixes outstanding",
                         quiet_cycles, predicted_mixes.size());
                $display("** signed_audio_soft_mixer_top: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed cases, then random phases
    // ------------------------------------------------------------------
    initial
    begin
        // source_count per random phase: every legal count, errors and saturation
        int phase_counts[NUM_PHASES];

        phase_counts = '{3, 8, 4, 2, 0, 5, 15, 6, 1, 7, 9, 3};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two sources at the reset count: extremes, zero, sign mix, half scale
        set_idle(MODE_FREE);
        frame_backlog.push_back(make_frame(16'sh7fff, 16'sh7fff, 16'sd0));
        frame_backlog.push_back(make_frame(16'sh8000, 16'sh8000, 16'sd0));
        frame_backlog.push_back(make_frame(16'sd0, 16'sh8000, 16'sd0));
        frame_backlog.push_back(make_frame(16'sd1, -16'sd1, 16'sd0));
        frame_backlog.push_back(make_frame(16'sh8000, 16'sh7fff, 16'sd0));
        frame_backlog.push_back(make_frame(16'sd16384, 16'sd16384, 16'sd0));

        // Three sources: walk every branch of the sign tree, full scale both ways
        write_source_count(4'd3);
        frame_backlog.push_back(make_frame(16'sh7fff, 16'sh7fff, 16'sh7fff));
        frame_backlog.push_back(make_frame(16'sh8000, 16'sh8000, 16'sh8000));
        frame_backlog.push_back(make_frame(16'sd20000, 16'sd20000, -16'sd5));
        frame_backlog.push_back(make_frame(16'sd5, -16'sd9, 16'sd7));
        frame_backlog.push_back(make_frame(16'sd300, 16'sd0, 16'sd400));
        frame_backlog.push_back(make_frame(16'sd300, 16'sd0, -16'sd400));
        frame_backlog.push_back(make_frame(-16'sd300, -16'sd300, 16'sd200));
        frame_backlog.push_back(make_frame(-16'sd1, 16'sh7fff, 16'sh8000));
        frame_backlog.push_back(make_frame(-16'sd300, 16'sd0, 16'sh8000));
        frame_backlog.push_back(make_frame(-16'sd300, 16'sd0, 16'sd1));
        frame_backlog.push_back(make_frame(16'sd0, -16'sd5, -16'sd6));

        // Full fold over eight sources at both rails
        write_source_count(4'd8);
        frame_backlog.push_back(make_frame(16'sh7fff, 16'sh7fff, 16'sh7fff));
        frame_backlog.push_back(make_frame(16'sh8000, 16'sh8000, 16'sh8000));

        // Count error below two, saturation of an oversized count
        write_source_count(4'd0);
        frame_backlog.push_back(make_frame(16'sh7fff, 16'sh8000, 16'sd1));
        write_source_count(4'd15);
        frame_backlog.push_back(make_frame(16'sh7fff, 16'sh7fff, 16'sh7fff));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_source_count(phase_counts[p][sasm_pkg::COUNT_W-1:0]);
            set_idle(p % 4);
            if (p == 2)
            begin
                // Pause the sender mid-phase until every mixed beat is back
                for (int i = 0; i < PHASE_ITEMS / 2; i++)
                    frame_backlog.push_back(random_frame());
                wait_all_mixed();
                for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++)
                    frame_backlog.push_back(random_frame());
            end
            else
            begin
                for (int i = 0; i < PHASE_ITEMS; i++)
                    frame_backlog.push_back(random_frame());
                // Long receiver hold-off so the pipeline fills and stalls its input
                if (p == 1 || p == 8)
                    hold_requests++;
            end
        end

        wait_all_mixed();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("mixed %0d frames under %0d source_count settings (error, saturated and",
                 frames_sent, settings_tried);
        $display("two to eight sources) through free-running, idle, stall and hold-off phases");
        if (mismatches == 0 && predicted_mixes.size() == 0)
        begin
            $display("** signed_audio_soft_mixer_top: PASSED **");
        end
        else
        begin
            $display("%0d mismatches, %0d mixes never seen", mismatches, predicted_mixes.size());
            $display("** signed_audio_soft_mixer_top: FAILED **");
        end
        $finish;
    end

endmodule
